// ===== hdl/gfau_pkg.sv =====
`default_nettype none
package gfau_pkg;

  localparam int FIELD_BITS = 8;
  localparam int FIELD_M = (FIELD_BITS < 1) ? 1 : ((FIELD_BITS > 8) ? 8 : FIELD_BITS);
  localparam int GROUP_ORDER = (1 << FIELD_M) - 1;

  localparam logic [7:0] FIELD_MASK = 8'(GROUP_ORDER);
  localparam logic [7:0] ALL_ONES = 8'hFF;

  typedef logic [8:0] poly_list_t [9];
  localparam poly_list_t PRIM_POLY_LIST = '{
    9'o003, 9'o003, 9'o007, 9'o013, 9'o023, 9'o045, 9'o103, 9'o211, 9'o435
  };
  localparam logic [8:0] PRIM_POLY = PRIM_POLY_LIST[FIELD_M];

  typedef enum logic [1:0] {
    FUNC_ADD = 2'd0,
    FUNC_MUL = 2'd1,
    FUNC_DIV = 2'd2,
    FUNC_MAC = 2'd3
  } func_t;

  typedef logic [7:0] byte_table_t [256];

  // multiply by x and reduce
  function automatic logic [7:0] mul_x(input logic [7:0] v);
    logic [8:0] r;
    r = {v, 1'b0};
    if (r[FIELD_M]) begin
      r = r ^ PRIM_POLY;
    end
    return r[7:0] & FIELD_MASK;
  endfunction

  function automatic byte_table_t build_inv_table();
    byte_table_t alog;
    byte_table_t inv;
    logic [7:0] x;
    int j;
    for (int i = 0; i < 256; i++) begin
      alog[i] = 8'd0;
      inv[i] = 8'd0;
    end
    x = 8'd1;
    for (int i = 0; i < GROUP_ORDER; i++) begin
      alog[i] = x;
      x = mul_x(x);
    end
    for (int i = 0; i < GROUP_ORDER; i++) begin
      j = (i == 0) ? 0 : GROUP_ORDER - i;
      inv[alog[i]] = alog[j];
    end
    return inv;
  endfunction

  localparam byte_table_t INV_TABLE = build_inv_table();

endpackage
`default_nettype wire

// ===== hdl/gfau_mul.sv =====
`default_nettype none
module gfau_mul (
  input  wire logic [7:0] a,
  input  wire logic [7:0] b,
  output logic      [7:0] product
);

  always_comb begin
    logic [8:0] r;
    r = 9'd0;
    for (int i = 7; i >= 0; i--) begin
      if (i < gfau_pkg::FIELD_M) begin
        r = {r[7:0], 1'b0};
        if (r[gfau_pkg::FIELD_M]) begin
          r = r ^ gfau_pkg::PRIM_POLY;
        end
        if (b[i]) begin
          r = r ^ {1'b0, a};
        end
      end
    end
    product = r[7:0] & gfau_pkg::FIELD_MASK;
  end

endmodule
`default_nettype wire

// ===== hdl/gf_arithmetic_unit_core.sv =====
`default_nettype none
// GF(2^m) arithmetic unit (add, multiply, divide, multiply-accumulate), m = 8 with
// polynomial 0435. One beat is taken on every cycle that start is high; busy is
// always low. Each beat's result passes through the s1, s2 and output registers,
// marked by done for one cycle, in order; the receiver cannot stall. The
// three stages are: divisor inverse from a 256-entry constant table, the field
// multiplier, then the final add and special-case selection. Division by zero
// returns 0xFF with divide_error set; region_last is carried to region_end.
module gf_arithmetic_unit_core (
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       start,
  output logic            busy,
  input  wire logic [1:0] func,
  input  wire logic [7:0] operand_a,
  input  wire logic [7:0] operand_b,
  input  wire logic [7:0] accumulator,
  input  wire logic       region_last,
  output logic            done,
  output logic      [7:0] result,
  output logic            divide_error,
  output logic            region_end
);

  logic                  s1_valid;
  gfau_pkg::func_t       s1_func;
  logic [7:0]            s1_a;
  logic [7:0]            s1_b;
  logic [7:0]            s1_acc;
  logic [7:0]            s1_inv;
  logic                  s1_last;

  logic                  s2_valid;
  gfau_pkg::func_t       s2_func;
  logic [7:0]            s2_sum;
  logic [7:0]            s2_prod;
  logic [7:0]            s2_acc;
  logic                  s2_bzero;
  logic                  s2_last;

  logic [7:0]            mul_b;
  logic [7:0]            mul_out;
  logic [7:0]            result_next;
  logic                  error_next;

  assign busy = 1'b0;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
      s2_valid <= 1'b0;
      done     <= 1'b0;
    end else begin
      s1_valid <= start && !busy;
      s2_valid <= s1_valid;
      done     <= s2_valid;
    end
  end

  always_ff @(posedge clk) begin
    s1_func <= gfau_pkg::func_t'(func);
    s1_a    <= operand_a & gfau_pkg::FIELD_MASK;
    s1_b    <= operand_b & gfau_pkg::FIELD_MASK;
    s1_acc  <= accumulator & gfau_pkg::FIELD_MASK;
    s1_inv  <= gfau_pkg::INV_TABLE[operand_b & gfau_pkg::FIELD_MASK];
    s1_last <= region_last;
  end

  assign mul_b = (s1_func == gfau_pkg::FUNC_DIV) ? s1_inv : s1_b;

  gfau_mul u_mul (
    .a       (s1_a),
    .b       (mul_b),
    .product (mul_out)
  );

  always_ff @(posedge clk) begin
    s2_func  <= s1_func;
    s2_sum   <= s1_a ^ s1_b;
    s2_prod  <= mul_out;
    s2_acc   <= s1_acc;
    s2_bzero <= (s1_b == 8'd0);
    s2_last  <= s1_last;
  end

  always_comb begin
    result_next = s2_sum;
    error_next  = 1'b0;
    case (s2_func)
      gfau_pkg::FUNC_ADD: result_next = s2_sum;
      gfau_pkg::FUNC_MUL: result_next = s2_prod;
      gfau_pkg::FUNC_DIV: begin
        if (s2_bzero) begin
          result_next = gfau_pkg::ALL_ONES;
          error_next  = 1'b1;
        end else begin
          result_next = s2_prod;
        end
      end
      gfau_pkg::FUNC_MAC: result_next = s2_acc ^ s2_prod;
      default:            result_next = s2_sum;
    endcase
  end

  always_ff @(posedge clk) begin
    result       <= result_next;
    divide_error <= error_next;
    region_end   <= s2_last;
  end

endmodule
`default_nettype wire
